FILE: rtl/core/bgbl_pkg.sv
// shared types, constants and duty table of the battery gauge
package bgbl_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int DUTY_W   = 8;
  localparam int SEG_W    = 2;

  // breathing phase runs 0 .. BREATHE_STEPS-1
  localparam int BREATHE_STEPS = 64;
  localparam int PHASE_W       = (BREATHE_STEPS > 2) ? $clog2(BREATHE_STEPS) : 1;

  // serial compare covers the widest level field
  localparam int CMP_W = MV_W;
  localparam int CNT_W = $clog2(CMP_W + 1);

  // packed port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HI = 2'd3;

  // threshold reset values
  localparam logic [MV_W-1:0]  VOLT_LO_RST   = 13'd3400;
  localparam logic [MV_W-1:0]  VOLT_HI_RST   = 13'd3800;
  localparam logic [PCT_W-1:0] CHARGE_LO_RST = 7'd34;
  localparam logic [PCT_W-1:0] CHARGE_HI_RST = 7'd67;

  // segment codes
  localparam logic [SEG_W-1:0] SEG_NONE = 2'd0;
  localparam logic [SEG_W-1:0] SEG_ONE  = 2'd1;
  localparam logic [SEG_W-1:0] SEG_TWO  = 2'd2;
  localparam logic [SEG_W-1:0] SEG_THREE = 2'd3;

  // opcode bits: bit 0 picks charge as level, bit 1 picks breathing
  localparam int OP_CHARGE_BIT  = 0;
  localparam int OP_BREATHE_BIT = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } gauge_state_t;

  // comparator control and status
  typedef struct packed {
    logic start;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic lt_lo;
    logic lt_hi;
  } cmp_stat_t;

  // breathing unit command
  typedef struct packed {
    logic             update;
    logic             breathe;
    logic [SEG_W-1:0] segs;
  } brth_cmd_t;

  typedef logic [DUTY_W-1:0] duty_lut_t [BREATHE_STEPS];

  // duty of one phase: piecewise remap then cubic easing
  function automatic logic [DUTY_W-1:0] duty_of_phase(int unsigned ph);
    int unsigned p;
    int unsigned cube;
    p = (ph * 100) / (BREATHE_STEPS - 1);
    if (p > 100) p = 100;
    if (p < 35) begin
      p = p * 2;
    end else if (p < 70) begin
      p = 70 + ((p - 35) * 25) / 35;
    end else begin
      p = 95 + ((p - 70) * 5) / 30;
    end
    cube = (p * p * p) / 10000;
    return DUTY_W'((cube * 255) / 100);
  endfunction

  function automatic duty_lut_t build_duty_lut();
    duty_lut_t lut;
    for (int i = 0; i < BREATHE_STEPS; i++) begin
      lut[i] = duty_of_phase(i);
    end
    return lut;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

FILE: rtl/core/bgbl_ser_cmp.sv
// bit-serial comparison of the level against both thresholds, lsb first
module bgbl_ser_cmp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bgbl_pkg::cmp_ctrl_t       ctrl,
  input  logic [bgbl_pkg::CMP_W-1:0] level,
  input  logic [bgbl_pkg::CMP_W-1:0] thr_lo,
  input  logic [bgbl_pkg::CMP_W-1:0] thr_hi,
  output bgbl_pkg::cmp_stat_t       stat
);
  import bgbl_pkg::*;

  logic [CMP_W-1:0] lvl_r, lvl_nxt;
  logic [CMP_W-1:0] lo_r, lo_nxt;
  logic [CMP_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lt_lo_r, lt_lo_nxt;
  logic             lt_hi_r, lt_hi_nxt;
  logic             busy;

  assign busy = (cnt_r != '0);

  // one bit per cycle; a higher bit overrides the lower verdict
  always_comb begin
    lvl_nxt   = lvl_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    lt_lo_nxt = lt_lo_r;
    lt_hi_nxt = lt_hi_r;
    if (ctrl.start) begin
      lvl_nxt   = level;
      lo_nxt    = thr_lo;
      hi_nxt    = thr_hi;
      cnt_nxt   = CNT_W'(CMP_W);
      lt_lo_nxt = 1'b0;
      lt_hi_nxt = 1'b0;
    end else if (busy) begin
      lt_lo_nxt = (~lvl_r[0] & lo_r[0]) | (~(lvl_r[0] ^ lo_r[0]) & lt_lo_r);
      lt_hi_nxt = (~lvl_r[0] & hi_r[0]) | (~(lvl_r[0] ^ hi_r[0]) & lt_hi_r);
      lvl_nxt   = lvl_r >> 1;
      lo_nxt    = lo_r >> 1;
      hi_nxt    = hi_r >> 1;
      cnt_nxt   = cnt_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // shift registers and verdicts
  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    lt_lo_r <= lt_lo_nxt;
    lt_hi_r <= lt_hi_nxt;
  end

  assign stat.busy  = busy;
  assign stat.lt_lo = lt_lo_r;
  assign stat.lt_hi = lt_hi_r;

endmodule

FILE: rtl/core/bgbl_breathe.sv
// breathing state: pulse mode, bouncing phase and duty lookup
module bgbl_breathe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bgbl_pkg::brth_cmd_t         cmd,
  output logic [bgbl_pkg::DUTY_W-1:0] duty
);
  import bgbl_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_TOP = PHASE_W'(BREATHE_STEPS - 1);

  logic [SEG_W-1:0]   mode_r, mode_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               rising_r, rising_nxt;
  logic [PHASE_W-1:0] phase_eff;
  logic               rising_eff;
  logic               restart;

  // a new pulsing segment restarts the breath from zero, rising
  assign restart    = (mode_r != cmd.segs);
  assign phase_eff  = restart ? '0 : phase_r;
  assign rising_eff = restart ? 1'b1 : rising_r;
  assign duty       = DUTY_LUT[phase_eff];

  // next breathing state
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    rising_nxt = rising_r;
    if (cmd.update) begin
      if (!cmd.breathe) begin
        mode_nxt   = SEG_NONE;
        phase_nxt  = '0;
        rising_nxt = 1'b1;
      end else begin
        mode_nxt   = cmd.segs;
        rising_nxt = rising_eff;
        if (rising_eff) begin
          if (phase_eff < PHASE_TOP) begin
            phase_nxt = phase_eff + 1'b1;
          end else begin
            rising_nxt = 1'b0;
            phase_nxt  = phase_eff - 1'b1;
          end
        end else begin
          if (phase_eff != '0) begin
            phase_nxt = phase_eff - 1'b1;
          end else begin
            rising_nxt = 1'b1;
            phase_nxt  = phase_eff + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SEG_NONE;
      phase_r  <= '0;
      rising_r <= 1'b1;
    end else begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      rising_r <= rising_nxt;
    end
  end

endmodule

FILE: rtl/core/battery_gauge_breathing_led.sv
// top level of the three-segment battery gauge with breathing top lit segment
//
// Each accepted item is finished before the next one is accepted: it is
// taken, the level is compared against both thresholds one bit per cycle
// across the 13-bit compare width set by the voltage field, the compare
// settles, and the result register is loaded and the breathing phase stepped
// once it is empty or being read. The result register frees the input side,
// so a new item may be taken while the previous result still waits downstream.
// Thresholds are written through the cfg port, which is always ready; write it
// only while the block is idle. Static opcodes light 1-3 segments; breathe
// opcodes pulse the top lit segment with a duty following an eased 0..63 phase.
module battery_gauge_breathing_led (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [12:0] cell_millivolts, [19:13] charge_percent, [23:20] zero
  input  logic [bgbl_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  logic [bgbl_pkg::OP_W-1:0]         in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] seg_low_on, [1] seg_mid_on, [2] seg_high_on, [4:3] pulse_segment,
  // [12:5] pulse_duty, [15:13] zero
  output logic [bgbl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // threshold writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgbl_pkg::MV_W-1:0]         cfg_data
);
  import bgbl_pkg::*;

  gauge_state_t     state_r, state_nxt;
  logic [MV_W-1:0]  volt_lo_r, volt_lo_nxt;
  logic [MV_W-1:0]  volt_hi_r, volt_hi_nxt;
  logic [PCT_W-1:0] chg_lo_r, chg_lo_nxt;
  logic [PCT_W-1:0] chg_hi_r, chg_hi_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic             in_xfer;
  logic             emit;
  logic             by_charge;
  logic [MV_W-1:0]  in_mv;
  logic [PCT_W-1:0] in_pct;
  logic [CMP_W-1:0] cmp_level;
  logic [CMP_W-1:0] cmp_lo;
  logic [CMP_W-1:0] cmp_hi;
  cmp_ctrl_t        cmp_ctrl;
  cmp_stat_t        cmp_stat;
  brth_cmd_t        brth_cmd;
  logic [DUTY_W-1:0] duty;
  logic [SEG_W-1:0] segs;
  logic             seg_low, seg_mid, seg_high;
  logic [SEG_W-1:0] pulse_seg;
  logic [DUTY_W-1:0] pulse_duty;

  assign in_mv     = in_tdata[MV_W-1:0];
  assign in_pct    = in_tdata[MV_W+PCT_W-1:MV_W];
  assign by_charge = in_tuser[OP_CHARGE_BIT];

  // level and thresholds for the chosen source
  assign cmp_level = by_charge ? CMP_W'(in_pct) : in_mv;
  assign cmp_lo    = by_charge ? CMP_W'(chg_lo_r) : volt_lo_r;
  assign cmp_hi    = by_charge ? CMP_W'(chg_hi_r) : volt_hi_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SHIFT;
      ST_SHIFT: if (!cmp_stat.busy) state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SHIFT: ;
      ST_EMIT:  emit = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  assign in_xfer        = in_tvalid && in_tready;
  assign cmp_ctrl.start = in_xfer;
  assign cfg_ready      = 1'b1;

  bgbl_ser_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cmp_ctrl),
    .level  (cmp_level),
    .thr_lo (cmp_lo),
    .thr_hi (cmp_hi),
    .stat   (cmp_stat)
  );

  // segment count from the compare verdicts, low threshold first
  always_comb begin
    if (cmp_stat.lt_lo) begin
      segs = SEG_ONE;
    end else if (cmp_stat.lt_hi) begin
      segs = SEG_TWO;
    end else begin
      segs = SEG_THREE;
    end
  end

  assign brth_cmd.update  = emit;
  assign brth_cmd.breathe = op_r[OP_BREATHE_BIT];
  assign brth_cmd.segs    = segs;

  bgbl_breathe u_breathe (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (brth_cmd),
    .duty  (duty)
  );

  // result fields; the pulsing segment and those above it read off
  always_comb begin
    if (op_r[OP_BREATHE_BIT]) begin
      seg_low    = (segs == SEG_TWO) || (segs == SEG_THREE);
      seg_mid    = (segs == SEG_THREE);
      seg_high   = 1'b0;
      pulse_seg  = segs;
      pulse_duty = duty;
    end else begin
      seg_low    = 1'b1;
      seg_mid    = (segs == SEG_TWO) || (segs == SEG_THREE);
      seg_high   = (segs == SEG_THREE);
      pulse_seg  = SEG_NONE;
      pulse_duty = '0;
    end
  end

  // result register and its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, pulse_duty, pulse_seg, seg_high, seg_mid, seg_low};
    end
  end

  // captured opcode
  assign op_nxt = in_xfer ? in_tuser : op_r;

  // threshold writes
  always_comb begin
    volt_lo_nxt = volt_lo_r;
    volt_hi_nxt = volt_hi_r;
    chg_lo_nxt  = chg_lo_r;
    chg_hi_nxt  = chg_hi_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VOLT_LO:   volt_lo_nxt = cfg_data;
        CFG_VOLT_HI:   volt_hi_nxt = cfg_data;
        CFG_CHARGE_LO: chg_lo_nxt  = cfg_data[PCT_W-1:0];
        CFG_CHARGE_HI: chg_hi_nxt  = cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      volt_lo_r   <= VOLT_LO_RST;
      volt_hi_r   <= VOLT_HI_RST;
      chg_lo_r    <= CHARGE_LO_RST;
      chg_hi_r    <= CHARGE_HI_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      volt_lo_r   <= volt_lo_nxt;
      volt_hi_r   <= volt_hi_nxt;
      chg_lo_r    <= chg_lo_nxt;
      chg_hi_r    <= chg_hi_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/tb.sv
// testbench for the three-segment battery gauge with breathing top lit segment
`timescale 1ns / 100ps

module tb;
  import bgbl_pkg::*;

  // opcodes
  localparam logic [OP_W-1:0] OP_STATIC_VOLT    = 2'd0;
  localparam logic [OP_W-1:0] OP_STATIC_CHARGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_BREATHE_VOLT   = 2'd2;
  localparam logic [OP_W-1:0] OP_BREATHE_CHARGE = 2'd3;

  localparam int MV_MAX          = 8191;
  localparam int PCT_MAX         = 127;
  localparam int PHASE_ITEMS     = 210;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_REPORTS     = 10;

  // one display result, lowest packed bit first in tdata
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [SEG_W-1:0]  pulse_seg;
    logic              seg_high;
    logic              seg_mid;
    logic              seg_low;
  } led_res_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    bit               typed;
    led_res_t         res;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [MV_W-1:0]        cfg_data;

  // typed expectation that travels with the item on the input bus
  bit        drv_typed;
  led_res_t  drv_ref;

  // predictor copy of thresholds and breathing state
  int unsigned volt_lo, volt_hi, charge_lo, charge_hi;
  int unsigned led_mode, led_phase;
  bit          led_rising;

  led_res_t  pending_leds[$];
  int        fail_cnt;
  int        stall_cnt;
  bit        tx_quiet;
  int        tx_cnt;
  bit        hold_req;
  dir_row_t  dir_rows[$];

  battery_gauge_breathing_led u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // number of lit segments for a level against two thresholds, low first
  function automatic logic [SEG_W-1:0] seg_count(int unsigned level, int unsigned lo,
                                                 int unsigned hi);
    if (level < lo) return SEG_ONE;
    if (level < hi) return SEG_TWO;
    return SEG_THREE;
  endfunction

  // eased duty of a breathing phase
  function automatic logic [DUTY_W-1:0] eased_duty(int unsigned ph);
    int unsigned pos;
    int unsigned lvl;
    int unsigned cube;
    logic [DUTY_W-1:0] d;
    pos = (ph * 100) / (BREATHE_STEPS - 1);
    if (pos > 100) pos = 100;
    if (pos < 35) lvl = 2 * pos;
    else if (pos < 70) lvl = 70 + ((pos - 35) * 25) / 35;
    else lvl = 95 + ((pos - 70) * 5) / 30;
    cube = (lvl * lvl * lvl) / 10000;
    d = DUTY_W'((cube * 255) / 100);
    return d;
  endfunction

  // expected display for one item, steps the breathing state
  function automatic led_res_t predict_leds(logic [OP_W-1:0] op, logic [MV_W-1:0] mv,
                                            logic [PCT_W-1:0] pct);
    logic [SEG_W-1:0] segs;
    led_res_t r;
    if (op[OP_CHARGE_BIT]) segs = seg_count(pct, charge_lo, charge_hi);
    else segs = seg_count(mv, volt_lo, volt_hi);
    r = '0;
    if (!op[OP_BREATHE_BIT]) begin
      led_mode   = 0;
      led_phase  = 0;
      led_rising = 1'b1;
      r.seg_low  = 1'b1;
      r.seg_mid  = (segs >= SEG_TWO);
      r.seg_high = (segs == SEG_THREE);
      return r;
    end
    if (led_mode != segs) begin
      led_mode   = segs;
      led_phase  = 0;
      led_rising = 1'b1;
    end
    r.seg_low   = (segs >= SEG_TWO);
    r.seg_mid   = (segs == SEG_THREE);
    r.pulse_seg = segs;
    r.duty      = eased_duty(led_phase);
    // bounce the phase between both ends
    if (led_rising) begin
      if (led_phase < BREATHE_STEPS - 1) led_phase++;
      else begin
        led_rising = 1'b0;
        led_phase--;
      end
    end else begin
      if (led_phase > 0) led_phase--;
      else begin
        led_rising = 1'b1;
        led_phase++;
      end
    end
    return r;
  endfunction

  // transfers on all three channels, predictor and result check
  always @(posedge clk) begin
    led_res_t got;
    led_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(led_res_t)-1:0];
        if (pending_leds.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected result transfer: %h", out_tdata);
        end else begin
          want = pending_leds.pop_front();
          if (got.seg_low !== want.seg_low || got.seg_mid !== want.seg_mid ||
              got.seg_high !== want.seg_high || got.pulse_seg !== want.pulse_seg ||
              got.duty !== want.duty) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("result mismatch: expected low %0d mid %0d high %0d seg %0d duty %0d,%s",
                       want.seg_low, want.seg_mid, want.seg_high, want.pulse_seg, want.duty,
                       $sformatf(" got low %0d mid %0d high %0d seg %0d duty %0d",
                                 got.seg_low, got.seg_mid, got.seg_high, got.pulse_seg,
                                 got.duty));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_leds(in_tuser, in_tdata[MV_W-1:0], in_tdata[MV_W+PCT_W-1:MV_W]);
        if (drv_typed) want = drv_ref;
        pending_leds.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOLT_LO:   volt_lo   = cfg_data;
          CFG_VOLT_HI:   volt_hi   = cfg_data;
          CFG_CHARGE_LO: charge_lo = cfg_data[PCT_W-1:0];
          CFG_CHARGE_HI: charge_hi = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random gaps, quiet stretches and one long hold-off
  initial begin
    int gap;
    int rx_cnt;
    bit rx_quiet;
    out_tready = 1'b0;
    rx_cnt = 0;
    rx_quiet = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_cnt % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      rx_cnt++;
      gap = rx_quiet ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one input transfer after a random gap, ends at the falling edge after it
  task automatic send_item(logic [OP_W-1:0] op, logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct,
                           bit typed, led_res_t res);
    int gap;
    if (tx_cnt % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    tx_cnt++;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - MV_W - PCT_W){1'b0}}, pct, mv};
    in_tuser  <= op;
    drv_typed <= typed;
    drv_ref   <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all four thresholds back to back
  task automatic set_thresholds(int unsigned vlo, int unsigned vhi, int unsigned clo,
                                int unsigned chi);
    logic [CFG_IDX_W-1:0] idx [4];
    int unsigned val [4];
    idx = '{CFG_VOLT_LO, CFG_VOLT_HI, CFG_CHARGE_LO, CFG_CHARGE_HI};
    val = '{vlo, vhi, clo, chi};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= MV_W'(val[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(logic [OP_W-1:0] op, int unsigned mv, int unsigned pct,
                                      bit typed, bit lo, bit mid, bit hi,
                                      logic [SEG_W-1:0] pseg, int unsigned duty);
    dir_row_t r;
    r.op = op;
    r.mv = MV_W'(mv);
    r.pct = PCT_W'(pct);
    r.typed = typed;
    r.res.seg_low = lo;
    r.res.seg_mid = mid;
    r.res.seg_high = hi;
    r.res.pulse_seg = pseg;
    r.res.duty = DUTY_W'(duty);
    return r;
  endfunction

  // level near a threshold, at an extreme or anywhere
  function automatic logic [MV_W-1:0] pick_mv();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = MV_MAX;
      2: v = int'(volt_lo) + $urandom_range(0, 6) - 3;
      3: v = int'(volt_hi) + $urandom_range(0, 6) - 3;
      default: v = $urandom_range(0, MV_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > MV_MAX) v = MV_MAX;
    return MV_W'(v);
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    int v;
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = 100;
      2: v = $urandom_range(101, PCT_MAX);
      3: v = int'(charge_lo) + $urandom_range(0, 4) - 2;
      4: v = int'(charge_hi) + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, 100);
    endcase
    if (v < 0) v = 0;
    if (v > PCT_MAX) v = PCT_MAX;
    return PCT_W'(v);
  endfunction

  // main sequence
  initial begin
    logic [OP_W-1:0]  op;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    int run;
    int n;
    int a;
    int b;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_STATIC_VOLT;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_VOLT_LO;
    cfg_data   = '0;
    drv_typed  = 1'b0;
    drv_ref    = '0;
    volt_lo    = VOLT_LO_RST;
    volt_hi    = VOLT_HI_RST;
    charge_lo  = CHARGE_LO_RST;
    charge_hi  = CHARGE_HI_RST;
    led_mode   = 0;
    led_phase  = 0;
    led_rising = 1'b1;
    fail_cnt   = 0;
    stall_cnt  = 0;
    tx_quiet   = 1'b0;
    tx_cnt     = 0;
    hold_req   = 1'b0;

    // directed rows at reset thresholds
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 0, 0, 1, 1, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, MV_MAX, PCT_MAX, 1, 1, 1, 1, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 3399, 0, 1, 1, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 3400, 0, 1, 1, 1, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 3799, 0, 1, 1, 1, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 3800, 0, 1, 1, 1, 1, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, MV_MAX, 0, 1, 1, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, 0, 33, 1, 1, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, 0, 34, 1, 1, 1, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, 0, 67, 1, 1, 1, 1, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, 0, 100, 1, 1, 1, 1, SEG_NONE, 0));
    // level above full charge still compares as three segments
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, 0, PCT_MAX, 1, 1, 1, 1, SEG_NONE, 0));
    // start breathing: phase 0, duty 0
    dir_rows.push_back(mk_row(OP_BREATHE_VOLT, MV_MAX, 0, 1, 1, 1, 0, SEG_THREE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_VOLT, 5000, 99, 0, 0, 0, 0, SEG_NONE, 0));
    // mode change while breathing restarts the phase
    dir_rows.push_back(mk_row(OP_BREATHE_VOLT, 3500, 0, 1, 1, 0, 0, SEG_TWO, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_CHARGE, MV_MAX, 10, 1, 0, 0, 0, SEG_ONE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_CHARGE, 0, 20, 0, 0, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_CHARGE, 0, PCT_MAX, 1, 1, 1, 0, SEG_THREE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_CHARGE, 1234, 90, 0, 0, 0, 0, SEG_NONE, 0));
    // static display stops breathing
    dir_rows.push_back(mk_row(OP_STATIC_VOLT, 0, 100, 1, 1, 0, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_VOLT, 0, PCT_MAX, 1, 0, 0, 0, SEG_ONE, 0));
    dir_rows.push_back(mk_row(OP_STATIC_CHARGE, MV_MAX, 50, 1, 1, 1, 0, SEG_NONE, 0));
    dir_rows.push_back(mk_row(OP_BREATHE_CHARGE, MV_MAX, 0, 1, 0, 0, 0, SEG_ONE, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].mv, dir_rows[i].pct, dir_rows[i].typed,
                dir_rows[i].res);
    drain();

    // random phases, each with its own threshold setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_thresholds(0, MV_MAX, 0, 100);
        1: set_thresholds(MV_MAX, 0, 100, 0);
        2: begin
          a = $urandom_range(0, MV_MAX);
          b = $urandom_range(0, MV_MAX);
          set_thresholds(a < b ? a : b, a < b ? b : a, 30, 70);
        end
        3: set_thresholds($urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                          $urandom_range(0, 100), $urandom_range(0, 100));
        4: set_thresholds(MV_MAX, MV_MAX, 100, 100);
        default: set_thresholds(VOLT_LO_RST, VOLT_HI_RST, CHARGE_LO_RST, CHARGE_HI_RST);
      endcase
      if (ph == 2) begin
        // long hold-off on the result side while items keep coming
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        tx_cnt   = 1;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // breathing run on a level that is only now and then re-picked, other field is random content
          op  = $urandom_range(0, 1) ? OP_BREATHE_CHARGE : OP_BREATHE_VOLT;
          run = $urandom_range(20, 150);
          mv  = pick_mv();
          pct = pick_pct();
          for (int k = 0; k < run && n < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 15) == 0) begin
              mv  = pick_mv();
              pct = pick_pct();
            end
            if (op == OP_BREATHE_CHARGE)
              send_item(op, MV_W'($urandom_range(0, MV_MAX)), pct, 1'b0, '0);
            else
              send_item(op, mv, PCT_W'($urandom_range(0, PCT_MAX)), 1'b0, '0);
            n++;
          end
        end else begin
          // short burst of arbitrary items
          run = $urandom_range(1, 8);
          for (int k = 0; k < run && n < PHASE_ITEMS; k++) begin
            op = OP_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
              send_item(op, pick_mv(), pick_pct(), 1'b0, '0);
            else
              send_item(op, MV_W'($urandom_range(0, MV_MAX)),
                        PCT_W'($urandom_range(0, PCT_MAX)), 1'b0, '0);
            n++;
          end
        end
      end
      drain();
    end

    if (pending_leds.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
